/* design/lot_pkg.sv */
// Shared types and constants for the limit order table.
package lot_pkg;

  localparam int TABLE_DEPTH = 64;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 200;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_EXECUTE = 2'd2;
  localparam logic [1:0] CMD_REPLACE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Request travelling down the cell chain, with its running results.
  typedef struct packed {
    logic        valid;
    logic [1:0]  cmd;
    logic [31:0] id;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic        dup;
    logic        done;
    logic        res_side;
    logic [31:0] res_price;
    logic [31:0] res_left;
    logic        bid_valid;
    logic [31:0] bid_price;
    logic [31:0] bid_order;
    logic        ask_valid;
    logic [31:0] ask_price;
    logic [31:0] ask_order;
  } wave_t;

endpackage

/* design/lot_cell.sv */
// One table slot: holds an order, applies the passing request, folds into best bid/ask.
module lot_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    probe_id,
  output logic           probe_hit,
  input  lot_pkg::wave_t wave_i,
  output lot_pkg::wave_t wave_o
);

  logic        live;
  logic [31:0] key;
  logic        side;
  logic [31:0] price;
  logic [31:0] left;

  logic        live_next;
  logic [31:0] key_next;
  logic        side_next;
  logic [31:0] price_next;
  logic [31:0] left_next;
  logic        hit;
  logic        take;
  logic        bid_better;
  logic        ask_better;
  lot_pkg::wave_t w;

  assign probe_hit = live && (key == probe_id);

  always_comb begin
    live_next  = live;
    key_next   = key;
    side_next  = side;
    price_next = price;
    left_next  = left;
    w          = wave_i;
    hit  = wave_i.valid && live && (key == wave_i.id) && (wave_i.cmd != lot_pkg::CMD_ADD);
    take = wave_i.valid && (wave_i.cmd == lot_pkg::CMD_ADD) && !wave_i.dup
           && !wave_i.done && !live;
    if (take) begin
      live_next  = 1'b1;
      key_next   = wave_i.id;
      side_next  = wave_i.side;
      price_next = wave_i.price;
      left_next  = wave_i.qty;
    end
    if (hit) begin
      case (wave_i.cmd)
        lot_pkg::CMD_CANCEL: live_next = 1'b0;
        lot_pkg::CMD_EXECUTE: begin
          if (wave_i.qty >= left) begin
            live_next = 1'b0;
            left_next = 32'd0;
          end else begin
            left_next = left - wave_i.qty;
          end
        end
        default: begin
          price_next = wave_i.price;
          left_next  = wave_i.qty;
        end
      endcase
    end
    if (take || hit) begin
      w.done      = 1'b1;
      w.res_side  = side_next;
      w.res_price = price_next;
      w.res_left  = left_next;
    end
    // fold this slot's post-request contents into the running best
    bid_better = live_next && !side_next &&
                 (!wave_i.bid_valid || price_next > wave_i.bid_price ||
                  (price_next == wave_i.bid_price && key_next < wave_i.bid_order));
    ask_better = live_next && side_next &&
                 (!wave_i.ask_valid || price_next < wave_i.ask_price ||
                  (price_next == wave_i.ask_price && key_next < wave_i.ask_order));
    if (bid_better) begin
      w.bid_valid = 1'b1;
      w.bid_price = price_next;
      w.bid_order = key_next;
    end
    if (ask_better) begin
      w.ask_valid = 1'b1;
      w.ask_price = price_next;
      w.ask_order = key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live         <= 1'b0;
      wave_o.valid <= 1'b0;
    end else begin
      if (wave_i.valid) begin
        live <= live_next;
      end
      wave_o.valid <= wave_i.valid;
    end
    if (wave_i.valid) begin
      key   <= key_next;
      side  <= side_next;
      price <= price_next;
      left  <= left_next;
    end
    {wave_o.cmd, wave_o.id, wave_o.side, wave_o.price, wave_o.qty, wave_o.dup,
     wave_o.done, wave_o.res_side, wave_o.res_price, wave_o.res_left,
     wave_o.bid_valid, wave_o.bid_price, wave_o.bid_order,
     wave_o.ask_valid, wave_o.ask_price, wave_o.ask_order} <=
    {w.cmd, w.id, w.side, w.price, w.qty, w.dup,
     w.done, w.res_side, w.res_price, w.res_left,
     w.bid_valid, w.bid_price, w.bid_order,
     w.ask_valid, w.ask_price, w.ask_order};
  end

endmodule

/* design/limit_order_table.sv */
// Limit order table: a chain of order slots with best bid/ask reporting.
//
// Each request enters the head of a chain of TABLE_DEPTH slot cells and moves one cell per
// clock; every cell applies the request to its own order and folds its contents into the
// running best bid and ask. The result is registered onto m_tdata/m_tvalid after it leaves
// the last cell, and the next request is accepted only once the previous one has left the
// chain and no result waits in the output buffer, so one request is in the chain at a time.
// Duplicate ids are found by a parallel key compare at acceptance; adds fill the lowest free
// slot. A two-entry output buffer lets a request enter while a result waits downstream.
// All slots are empty after reset.
module limit_order_table #(
  parameter int TABLE_DEPTH = lot_pkg::TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // id[31:0], side[32], price[64:33], quantity[96:65], zero pad
  input  logic [lot_pkg::IN_DATA_W-1:0]  s_tdata,
  // command[1:0]
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // order_side[0], order_price[32:1], order_remaining[64:33], bid_valid[65],
  // bid_price[97:66], bid_order[129:98], ask_valid[130], ask_price[162:131],
  // ask_order[194:163], zero pad
  output logic [lot_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]                     m_tuser
);

  lot_pkg::wave_t chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] hits;

  logic        busy;
  logic        pend_valid;
  logic [1:0]  pend_user;
  logic [lot_pkg::OUT_DATA_W-1:0] pend_data;
  logic        accept;
  logic        m_free;
  logic [1:0]  res_user;
  logic [lot_pkg::OUT_DATA_W-1:0] res_data;
  lot_pkg::wave_t last;

  assign s_tready = !busy && !pend_valid;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = accept;
    chain[0].cmd   = s_tuser;
    chain[0].id    = s_tdata[31:0];
    chain[0].side  = s_tdata[32];
    chain[0].price = s_tdata[64:33];
    chain[0].qty   = s_tdata[96:65];
    chain[0].dup   = |hits;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lot_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .probe_id (s_tdata[31:0]),
      .probe_hit(hits[i]),
      .wave_i   (chain[i]),
      .wave_o   (chain[i+1])
    );
  end

  assign last = chain[TABLE_DEPTH];

  always_comb begin
    if (last.cmd == lot_pkg::CMD_ADD) begin
      res_user = last.dup ? lot_pkg::ST_DUP : (last.done ? lot_pkg::ST_OK : lot_pkg::ST_FULL);
    end else begin
      res_user = last.done ? lot_pkg::ST_OK : lot_pkg::ST_MISSING;
    end
    res_data = {5'd0, last.ask_order, last.ask_price, last.ask_valid,
                last.bid_order, last.bid_price, last.bid_valid,
                last.res_left, last.res_price, last.res_side};
  end

  assign m_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (last.valid) begin
        busy <= 1'b0;
      end
      if (m_free) begin
        if (pend_valid) begin
          m_tvalid   <= 1'b1;
          pend_valid <= last.valid;
        end else begin
          m_tvalid <= last.valid;
        end
      end else if (last.valid) begin
        pend_valid <= 1'b1;
      end
    end
    if (m_free) begin
      if (pend_valid) begin
        m_tdata <= pend_data;
        m_tuser <= pend_user;
        if (last.valid) begin
          pend_data <= res_data;
          pend_user <= res_user;
        end
      end else if (last.valid) begin
        m_tdata <= res_data;
        m_tuser <= res_user;
      end
    end else if (last.valid) begin
      pend_data <= res_data;
      pend_user <= res_user;
    end
  end

endmodule

/* design/lot_checker.sv */
// Port-level assertions for the limit order table, bound to the top level.
module lot_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lot_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                     m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // failed requests report no order
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != lot_pkg::ST_OK) |-> (m_tdata[64:0] == 65'd0))
    else $error("order fields set on failed request");

  a_bid_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[65] |-> (m_tdata[129:66] == 64'd0))
    else $error("bid fields set with no bid");

  a_ask_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[130] |-> (m_tdata[194:131] == 64'd0))
    else $error("ask fields set with no ask");

endmodule

bind limit_order_table lot_checker u_lot_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

/* tb/testbench.sv */
// Testbench for the limit order table: random order traffic checked against a local book model.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = lot_pkg::TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] id;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
  } order_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        side;
    logic [31:0] price;
    logic [31:0] left;
    logic        bid_valid;
    logic [31:0] bid_price;
    logic [31:0] bid_order;
    logic        ask_valid;
    logic [31:0] ask_price;
    logic [31:0] ask_order;
  } book_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [lot_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [lot_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  limit_order_table DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // book copy used for prediction
  logic        book_live [DEPTH];
  logic [31:0] book_key [DEPTH];
  logic        book_side [DEPTH];
  logic [31:0] book_price [DEPTH];
  logic [31:0] book_left [DEPTH];

  order_req_t pending_reqs[$];
  book_resp_t expected_resps[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void best_side(input logic want, output logic v, output logic [31:0] p,
                                    output logic [31:0] id);
    bit better;
    v = 0; p = 0; id = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (book_live[i] && book_side[i] == want) begin
        if (!v) better = 1;
        else if (book_price[i] == p) better = book_key[i] < id;
        else if (want == 1'b0) better = book_price[i] > p;
        else better = book_price[i] < p;
        if (better) begin
          v = 1; p = book_price[i]; id = book_key[i];
        end
      end
    end
  endfunction

  function automatic book_resp_t apply_order(input order_req_t r);
    book_resp_t e;
    int slot = -1;
    int free = -1;
    e = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (book_live[i] && book_key[i] == r.id) slot = i;
      if (!book_live[i]) free = i;
    end
    if (r.cmd == lot_pkg::CMD_ADD) begin
      if (slot >= 0) e.status = lot_pkg::ST_DUP;
      else if (free < 0) e.status = lot_pkg::ST_FULL;
      else begin
        book_live[free] = 1; book_key[free] = r.id; book_side[free] = r.side;
        book_price[free] = r.price; book_left[free] = r.qty;
        e.side = r.side; e.price = r.price; e.left = r.qty;
      end
    end else if (slot < 0) begin
      e.status = lot_pkg::ST_MISSING;
    end else begin
      if (r.cmd == lot_pkg::CMD_CANCEL) book_live[slot] = 0;
      else if (r.cmd == lot_pkg::CMD_EXECUTE) begin
        if (r.qty >= book_left[slot]) begin
          book_live[slot] = 0; book_left[slot] = 0;
        end else book_left[slot] -= r.qty;
      end else begin
        book_price[slot] = r.price; book_left[slot] = r.qty;
      end
      e.side = book_side[slot]; e.price = book_price[slot]; e.left = book_left[slot];
    end
    best_side(1'b0, e.bid_valid, e.bid_price, e.bid_order);
    best_side(1'b1, e.ask_valid, e.ask_price, e.ask_order);
    return e;
  endfunction

  // driver
  always @(posedge clk) begin
    order_req_t r;
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          expected_resps.insert(expected_resps.size(), apply_order(r));
          s_tuser <= r.cmd;
          s_tdata <= {7'd0, r.qty, r.price, r.side, r.id};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and output backpressure
  always @(posedge clk) begin
    book_resp_t e;
    book_resp_t g;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        g.status    = m_tuser;
        g.side      = m_tdata[0];
        g.price     = m_tdata[32:1];
        g.left      = m_tdata[64:33];
        g.bid_valid = m_tdata[65];
        g.bid_price = m_tdata[97:66];
        g.bid_order = m_tdata[129:98];
        g.ask_valid = m_tdata[130];
        g.ask_price = m_tdata[162:131];
        g.ask_order = m_tdata[194:163];
        if (expected_resps.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          e = expected_resps.pop_front();
          if (g.status != e.status) report("status", 32'(g.status), 32'(e.status));
          if (g.side != e.side) report("order_side", 32'(g.side), 32'(e.side));
          if (g.price != e.price) report("order_price", g.price, e.price);
          if (g.left != e.left) report("order_remaining", g.left, e.left);
          if (g.bid_valid != e.bid_valid)
            report("bid_valid", 32'(g.bid_valid), 32'(e.bid_valid));
          if (g.bid_price != e.bid_price) report("bid_price", g.bid_price, e.bid_price);
          if (g.bid_order != e.bid_order) report("bid_order", g.bid_order, e.bid_order);
          if (g.ask_valid != e.ask_valid)
            report("ask_valid", 32'(g.ask_valid), 32'(e.ask_valid));
          if (g.ask_price != e.ask_price) report("ask_price", g.ask_price, e.ask_price);
          if (g.ask_order != e.ask_order) report("ask_order", g.ask_order, e.ask_order);
        end
      end
      m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (!rst);
    repeat (600) @(posedge clk);
    hold_off = 1;
    repeat (800) @(posedge clk);
    hold_off = 0;
  end

  logic [31:0] live_ids[$];

  function automatic logic [31:0] pick_id();
    if (live_ids.size() > 0 && $urandom_range(9) < 8)
      return live_ids[$urandom_range(live_ids.size() - 1)];
    return $urandom_range(40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return 100 + $urandom_range(20);
    endcase
  endfunction

  task automatic queue_order(input logic [1:0] c, input logic [31:0] id, input logic s,
                             input logic [31:0] p, input logic [31:0] q);
    order_req_t r;
    r.cmd = c; r.id = id; r.side = s; r.price = p; r.qty = q;
    pending_reqs.insert(pending_reqs.size(), r);
    if (c == lot_pkg::CMD_ADD) live_ids.insert(live_ids.size(), id);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [1:0] c;
    for (int i = 0; i < DEPTH; i++) begin
      book_live[i] = 0; book_key[i] = 0; book_side[i] = 0;
      book_price[i] = 0; book_left[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, duplicate, missing ids, execute partial/full, replace to zero
    queue_order(lot_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_order(lot_pkg::CMD_ADD, 32'd0, 1'b1, 32'd0, 32'd0);
    queue_order(lot_pkg::CMD_ADD, 32'd5, 1'b0, 32'hFFFF_FFFF, 32'd10);
    queue_order(lot_pkg::CMD_ADD, 32'd7, 1'b1, 32'd0, 32'd10);
    queue_order(lot_pkg::CMD_ADD, 32'd5, 1'b1, 32'd3, 32'd3);
    queue_order(lot_pkg::CMD_CANCEL, 32'd99, 1'b0, 32'd0, 32'd0);
    queue_order(lot_pkg::CMD_EXECUTE, 32'd99, 1'b0, 32'd0, 32'd1);
    queue_order(lot_pkg::CMD_REPLACE, 32'd99, 1'b0, 32'd1, 32'd1);
    queue_order(lot_pkg::CMD_EXECUTE, 32'd5, 1'b0, 32'd0, 32'd4);
    queue_order(lot_pkg::CMD_EXECUTE, 32'd5, 1'b0, 32'd0, 32'd6);
    queue_order(lot_pkg::CMD_EXECUTE, 32'd7, 1'b1, 32'd0, 32'hFFFF_FFFF);
    queue_order(lot_pkg::CMD_REPLACE, 32'd0, 1'b0, 32'h1234_5678, 32'd0);
    queue_order(lot_pkg::CMD_CANCEL, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0);
    queue_order(lot_pkg::CMD_CANCEL, 32'd0, 1'b0, 32'd0, 32'd0);
    // fill the table past its depth
    for (int i = 0; i < DEPTH + 2; i++)
      queue_order(lot_pkg::CMD_ADD, 32'd1000 + i, i[0], 32'd50, 32'd1);
    for (int i = 0; i < DEPTH; i++)
      queue_order(lot_pkg::CMD_CANCEL, 32'd1000 + i, 1'b0, 32'd0, 32'd0);
    live_ids.delete();

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 81 : 10) : 0;
      recv_stall_pct = (ph == 2) ? 81 : (ph == 3 ? 10 : 0);
      for (int n = 0; n < 170; n++) begin
        c = $urandom_range(3);
        if (live_ids.size() < 8 && $urandom_range(1)) c = lot_pkg::CMD_ADD;
        queue_order(c, c == lot_pkg::CMD_ADD ?
                         ($urandom_range(3) == 0 ? $urandom : $urandom_range(200))
                       : pick_id(),
                    $urandom_range(1), rand_word(), rand_word());
        if (live_ids.size() > 100) void'(live_ids.pop_front());
      end
    end
    drain();
    repeat (DEPTH * 4) @(posedge clk);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
